FILE: rtl/fdm_pkg.sv
package fdm_pkg;

   localparam int PAYLOAD_BYTES = 35;
   localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int POS_W = 6;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(PAYLOAD_BYTES - 1);
   localparam logic [15:0] PAYLOAD_LEN = 16'(PAYLOAD_BYTES);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // sync word, first byte in the lowest lane: 'F' 'D' 'M' '1'
   localparam logic [3:0][7:0] SYNC_WORD = 32'h314D4446;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_ERR_LEN,
      CMD_ERR_CRC,
      CMD_FRAME
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_BAD_LEN = 2'd1,
      KIND_BAD_CRC = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [7:0]        data;
      logic [ADDR_W-1:0] addr;
   } entry_type;

   // crc-16/ccitt-false, one byte msb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/fdm_front.sv
module fdm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte,
   output logic                push_valid,
   output fdm_pkg::entry_type  push_entry,
   input  logic                push_ready
);

   fdm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]                 sync_ff, sync_in;
   logic [7:0]                 len_lo_ff, len_lo_in;
   logic [fdm_pkg::ADDR_W-1:0] count_ff, count_in;
   logic [15:0]                crc_ff, crc_in;
   logic [7:0]                 crc_lo_ff, crc_lo_in;

   logic        accept;
   logic [15:0] crc_next;
   logic [15:0] len_word;
   logic [15:0] crc_word;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign crc_next  = fdm_pkg::crc_feed(crc_ff, req_byte);
   assign len_word  = {req_byte, len_lo_ff};
   assign crc_word  = {req_byte, crc_lo_ff};

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            fdm_pkg::PH_LEN_LO: phase_in = fdm_pkg::PH_LEN_HI;
            fdm_pkg::PH_LEN_HI: begin
               phase_in = (len_word == fdm_pkg::PAYLOAD_LEN) ? fdm_pkg::PH_DATA
                                                             : fdm_pkg::PH_HUNT;
            end
            fdm_pkg::PH_DATA: begin
               if (count_ff == fdm_pkg::LAST_IDX) begin
                  phase_in = fdm_pkg::PH_CRC_LO;
               end
            end
            fdm_pkg::PH_CRC_LO: phase_in = fdm_pkg::PH_CRC_HI;
            fdm_pkg::PH_CRC_HI: phase_in = fdm_pkg::PH_HUNT;
            default: begin
               if (req_byte == fdm_pkg::SYNC_WORD[sync_ff] && sync_ff == 2'd3) begin
                  phase_in = fdm_pkg::PH_LEN_LO;
               end else begin
                  phase_in = fdm_pkg::PH_HUNT;
               end
            end
         endcase
      end
   end

   // datapath and queue commands
   always_comb begin
      sync_in    = sync_ff;
      len_lo_in  = len_lo_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      push_valid = 1'b0;
      push_entry.cmd  = fdm_pkg::CMD_WRITE;
      push_entry.data = req_byte;
      push_entry.addr = count_ff;
      if (accept) begin
         unique case (phase_ff)
            fdm_pkg::PH_LEN_LO: len_lo_in = req_byte;
            fdm_pkg::PH_LEN_HI: begin
               len_lo_in = 8'd0;
               count_in  = '0;
               crc_in    = fdm_pkg::CRC_INIT;
               if (len_word != fdm_pkg::PAYLOAD_LEN) begin
                  push_valid     = 1'b1;
                  push_entry.cmd = fdm_pkg::CMD_ERR_LEN;
               end
            end
            fdm_pkg::PH_DATA: begin
               push_valid = 1'b1;
               crc_in     = crc_next;
               if (count_ff != fdm_pkg::LAST_IDX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            fdm_pkg::PH_CRC_LO: crc_lo_in = req_byte;
            fdm_pkg::PH_CRC_HI: begin
               push_valid     = 1'b1;
               push_entry.cmd = (crc_word == crc_ff) ? fdm_pkg::CMD_FRAME
                                                     : fdm_pkg::CMD_ERR_CRC;
               count_in  = '0;
               crc_in    = fdm_pkg::CRC_INIT;
               crc_lo_in = 8'd0;
            end
            default: begin
               if (req_byte == fdm_pkg::SYNC_WORD[sync_ff]) begin
                  sync_in = (sync_ff == 2'd3) ? 2'd0 : sync_ff + 2'd1;
               end else begin
                  sync_in = (req_byte == fdm_pkg::SYNC_WORD[0]) ? 2'd1 : 2'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fdm_pkg::PH_HUNT;
         sync_ff   <= 2'd0;
         len_lo_ff <= 8'd0;
         count_ff  <= '0;
         crc_ff    <= fdm_pkg::CRC_INIT;
         crc_lo_ff <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         sync_ff   <= sync_in;
         len_lo_ff <= len_lo_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

FILE: rtl/fdm_queue.sv
module fdm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  fdm_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fdm_pkg::entry_type  pop_entry
);

   fdm_pkg::entry_type slots_ff [fdm_pkg::QUEUE_DEPTH];
   logic [fdm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fdm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fdm_pkg::QPTR_W:0]   fill_ff, fill_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (fill_ff != (fdm_pkg::QPTR_W + 1)'(fdm_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/fdm_back.sv
module fdm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  fdm_pkg::entry_type         pop_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fdm_pkg::kind_type          out_kind,
   output logic [7:0]                 out_byte,
   output logic [fdm_pkg::POS_W-1:0]  out_pos,
   output logic                       out_last
);

   logic [7:0] store [fdm_pkg::PAYLOAD_BYTES];

   fdm_pkg::back_state_type st_ff, st_in;
   logic [fdm_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]                 rd_data_ff;

   logic                       out_valid_ff;
   fdm_pkg::kind_type          out_kind_ff;
   logic [7:0]                 out_byte_ff;
   logic [fdm_pkg::POS_W-1:0]  out_pos_ff;
   logic                       out_last_ff;

   logic                       out_free;
   logic                       we;
   logic                       load;
   fdm_pkg::kind_type          ld_kind;
   logic [7:0]                 ld_byte;
   logic [fdm_pkg::POS_W-1:0]  ld_pos;
   logic                       ld_last;

   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_byte  = out_byte_ff;
   assign out_pos   = out_pos_ff;
   assign out_last  = out_last_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         fdm_pkg::BK_IDLE: begin
            if (pop_valid && pop_entry.cmd == fdm_pkg::CMD_FRAME) begin
               st_in = fdm_pkg::BK_FETCH;
            end
         end
         fdm_pkg::BK_FETCH: st_in = fdm_pkg::BK_EMIT;
         fdm_pkg::BK_EMIT: begin
            if (out_free) begin
               st_in = (idx_ff == fdm_pkg::LAST_IDX) ? fdm_pkg::BK_IDLE : fdm_pkg::BK_FETCH;
            end
         end
         default: st_in = fdm_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      we        = 1'b0;
      load      = 1'b0;
      ld_kind   = fdm_pkg::KIND_DATA;
      ld_byte   = 8'd0;
      ld_pos    = '0;
      ld_last   = 1'b0;
      idx_in    = idx_ff;
      unique case (st_ff)
         fdm_pkg::BK_IDLE: begin
            if (pop_valid) begin
               unique case (pop_entry.cmd)
                  fdm_pkg::CMD_WRITE: begin
                     pop_ready = 1'b1;
                     we        = 1'b1;
                  end
                  fdm_pkg::CMD_ERR_LEN, fdm_pkg::CMD_ERR_CRC: begin
                     if (out_free) begin
                        pop_ready = 1'b1;
                        load      = 1'b1;
                        ld_last   = 1'b1;
                        ld_kind   = (pop_entry.cmd == fdm_pkg::CMD_ERR_LEN)
                                    ? fdm_pkg::KIND_BAD_LEN : fdm_pkg::KIND_BAD_CRC;
                     end
                  end
                  fdm_pkg::CMD_FRAME: begin
                     pop_ready = 1'b1;
                     idx_in    = '0;
                  end
                  default: pop_ready = 1'b0;
               endcase
            end
         end
         fdm_pkg::BK_EMIT: begin
            if (out_free) begin
               load    = 1'b1;
               ld_byte = rd_data_ff;
               ld_pos  = fdm_pkg::POS_W'(idx_ff);
               ld_last = (idx_ff == fdm_pkg::LAST_IDX);
               if (idx_ff != fdm_pkg::LAST_IDX) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= fdm_pkg::BK_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff <= ld_kind;
         out_byte_ff <= ld_byte;
         out_pos_ff  <= ld_pos;
         out_last_ff <= ld_last;
      end
   end

   // payload store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         store[pop_entry.addr] <= pop_entry.data;
      end
      rd_data_ff <= store[idx_ff];
   end

endmodule

FILE: rtl/framed_byte_receiver_crc16.sv
// channel | direction | beat contents
// req_*   | in        | tdata[7:0] rx_byte
// rsp_*   | out       | tdata[7:0] frame_byte, tdata[13:8] byte_position,
//         |           | tuser[1:0] kind, tlast last
//
// the front end takes one byte per cycle while the command queue has room
// a good frame is read back from the payload store through a fetch and an emit
// state per byte (registered store read), and the queue is not popped meanwhile
// bytes that follow a frame are still taken until the four-entry queue fills
// reset is synchronous and returns to the sync hunt; the store needs no clearing
module framed_byte_receiver_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] frame_byte, [13:8] byte_position, [15:14] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   logic               push_valid;
   logic               push_ready;
   fdm_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_ready;
   fdm_pkg::entry_type pop_entry;

   fdm_pkg::kind_type          out_kind;
   logic [7:0]                 out_byte;
   logic [fdm_pkg::POS_W-1:0]  out_pos;

   fdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_byte   (req_tdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   fdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   fdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (out_kind),
      .out_byte  (out_byte),
      .out_pos   (out_pos),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_pos, out_byte};
   assign rsp_tuser = out_kind;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int RX_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      fdm_pkg::kind_type          kind;
      logic [7:0]                 data;
      logic [fdm_pkg::POS_W-1:0]  pos;
      logic                       last;
   } rsp_beat_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_EXTREMES
   } fill_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   framed_byte_receiver_crc16 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and scoreboard state
   logic [7:0]   pending_bytes[$];
   rsp_beat_type expected_beats[$];
   int          queued_count   = 0;
   int          accepted_count = 0;
   int          error_count    = 0;
   int          cycle_count    = 0;
   int          tx_idle_pct    = 0;
   int          rx_stall_pct   = 0;
   logic        rx_hold        = 1'b0;
   logic        hold_armed     = 1'b0;
   int          frames_passed  = 0;
   int          bad_len_seen   = 0;
   int          bad_crc_seen   = 0;
   int          data_beats     = 0;

   // receiver model state
   fdm_pkg::phase_type         rx_phase  = fdm_pkg::PH_HUNT;
   logic [1:0]                 sync_count = 2'd0;
   logic [15:0]                frame_len = 16'h0000;
   logic [fdm_pkg::POS_W-1:0]  pay_idx   = '0;
   logic [15:0]                crc_acc   = fdm_pkg::CRC_INIT;
   logic [7:0]                 crc_lo    = 8'h00;
   logic [7:0]                 pay_buf[fdm_pkg::PAYLOAD_BYTES];

   function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? fdm_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void restart_hunt();
      rx_phase   = fdm_pkg::PH_HUNT;
      sync_count = 2'd0;
      frame_len  = 16'h0000;
      pay_idx    = '0;
      crc_acc    = fdm_pkg::CRC_INIT;
      crc_lo     = 8'h00;
   endfunction

   function automatic void predict_rx_byte(input logic [7:0] b);
      logic [15:0] got_crc;
      case (rx_phase)
         fdm_pkg::PH_LEN_LO: begin
            frame_len = {8'h00, b};
            rx_phase  = fdm_pkg::PH_LEN_HI;
         end
         fdm_pkg::PH_LEN_HI: begin
            // full 16-bit compare, a nonzero high byte is a bad length too
            frame_len[15:8] = b;
            if (frame_len != fdm_pkg::PAYLOAD_LEN) begin
               expected_beats.push_back('{kind: fdm_pkg::KIND_BAD_LEN, data: 8'h00,
                                          pos: '0, last: 1'b1});
               restart_hunt();
            end else begin
               pay_idx  = '0;
               crc_acc  = fdm_pkg::CRC_INIT;
               rx_phase = fdm_pkg::PH_DATA;
            end
         end
         fdm_pkg::PH_DATA: begin
            if (pay_idx < fdm_pkg::PAYLOAD_BYTES) pay_buf[pay_idx] = b;
            crc_acc = crc16_ccitt_byte(crc_acc, b);
            if (pay_idx >= fdm_pkg::PAYLOAD_BYTES - 1) begin
               rx_phase = fdm_pkg::PH_CRC_LO;
            end else begin
               pay_idx = pay_idx + 1'b1;
            end
         end
         fdm_pkg::PH_CRC_LO: begin
            crc_lo   = b;
            rx_phase = fdm_pkg::PH_CRC_HI;
         end
         fdm_pkg::PH_CRC_HI: begin
            got_crc = {b, crc_lo};
            if (got_crc == crc_acc) begin
               for (int i = 0; i < fdm_pkg::PAYLOAD_BYTES; i++) begin
                  expected_beats.push_back('{kind: fdm_pkg::KIND_DATA, data: pay_buf[i],
                                             pos: fdm_pkg::POS_W'(i),
                                             last: (i == fdm_pkg::PAYLOAD_BYTES - 1)});
               end
            end else begin
               expected_beats.push_back('{kind: fdm_pkg::KIND_BAD_CRC, data: 8'h00,
                                          pos: '0, last: 1'b1});
            end
            restart_hunt();
         end
         default: begin
            // sync hunt, unused phase codes land here as well
            rx_phase = fdm_pkg::PH_HUNT;
            if (b == fdm_pkg::SYNC_WORD[sync_count]) begin
               if (sync_count == 2'd3) begin
                  sync_count = 2'd0;
                  rx_phase   = fdm_pkg::PH_LEN_LO;
               end else begin
                  sync_count = sync_count + 1'b1;
               end
            end else begin
               sync_count = (b == fdm_pkg::SYNC_WORD[0]) ? 2'd1 : 2'd0;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("testbench: mismatch %s got 0x%0h want 0x%0h at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_rx_byte(req_tdata);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_tdata  <= pending_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat tdata", rsp_tdata, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tuser != want.kind) report_mismatch("kind", rsp_tuser, want.kind);
               if (rsp_tdata[7:0] != want.data)
                  report_mismatch("frame_byte", rsp_tdata[7:0], want.data);
               if (rsp_tdata[13:8] != want.pos)
                  report_mismatch("byte_position", rsp_tdata[13:8], want.pos);
               if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
            end
            case (rsp_tuser)
               fdm_pkg::KIND_DATA: begin
                  data_beats++;
                  if (rsp_tlast) frames_passed++;
               end
               fdm_pkg::KIND_BAD_LEN: bad_len_seen++;
               default: bad_crc_seen++;
            endcase
         end
         rsp_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // long receiver hold-off so the input side backs up
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_count++;
   endtask

   task automatic push_sync();
      for (int i = 0; i < 4; i++) push_byte(fdm_pkg::SYNC_WORD[i]);
   endtask

   task automatic push_word16(input logic [15:0] w);
      push_byte(w[7:0]);
      push_byte(w[15:8]);
   endtask

   task automatic push_bad_length(input logic [15:0] len);
      push_sync();
      push_word16(len);
   endtask

   task automatic push_frame(input fill_mode_type fill, input logic corrupt_crc);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = fdm_pkg::CRC_INIT;
      push_sync();
      push_word16(fdm_pkg::PAYLOAD_LEN);
      for (int i = 0; i < fdm_pkg::PAYLOAD_BYTES; i++) begin
         if (fill == FILL_EXTREMES) b = (i % 2 == 0) ? 8'h00 : 8'hFF;
         else b = 8'($urandom_range(255));
         crc = crc16_ccitt_byte(crc, b);
         push_byte(b);
      end
      if (corrupt_crc) crc[$urandom_range(15)] ^= 1'b1;
      push_word16(crc);
   endtask

   task automatic wait_all_done();
      while (accepted_count != queued_count) @(negedge clock);
      while (expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic random_traffic(input int target_items);
      int          sent;
      int          pick;
      int          n;
      logic [15:0] len;
      sent = 0;
      while (sent < target_items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            push_frame(FILL_RANDOM, 1'b0);
            sent += fdm_pkg::PAYLOAD_BYTES + 8;
         end else if (pick < 70) begin
            push_frame(FILL_RANDOM, 1'b1);
            sent += fdm_pkg::PAYLOAD_BYTES + 8;
         end else if (pick < 80) begin
            if ($urandom_range(1)) begin
               len = {8'($urandom_range(1, 255)), fdm_pkg::PAYLOAD_LEN[7:0]};
            end else begin
               len = 16'($urandom_range(65535));
               if (len == fdm_pkg::PAYLOAD_LEN) len = len + 1'b1;
            end
            push_bad_length(len);
            sent += 6;
         end else if (pick < 90) begin
            // partial sync word broken by a random byte
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) push_byte(fdm_pkg::SYNC_WORD[i]);
            push_byte(8'($urandom_range(255)));
            sent += n + 1;
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
            sent += n;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: hunt corner cases, both length errors, good and bad frame
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(fdm_pkg::SYNC_WORD[0]);
      push_byte(fdm_pkg::SYNC_WORD[1]);
      push_byte(fdm_pkg::SYNC_WORD[0]);   // restarts the hunt at one byte matched
      push_byte(fdm_pkg::SYNC_WORD[1]);
      push_byte(fdm_pkg::SYNC_WORD[2]);
      push_byte(8'h00);
      push_bad_length({8'h01, fdm_pkg::PAYLOAD_LEN[7:0]});
      push_bad_length(16'hFFFF);
      push_frame(FILL_EXTREMES, 1'b0);
      push_frame(FILL_EXTREMES, 1'b1);
      wait_all_done();

      tx_idle_pct  = 69;
      rx_stall_pct = 0;
      random_traffic(50);
      wait_all_done();

      tx_idle_pct  = 0;
      rx_stall_pct = 69;
      random_traffic(50);
      wait_all_done();

      tx_idle_pct  = 6;
      rx_stall_pct = 6;
      random_traffic(50);
      wait_all_done();

      // no idling, receiver held off while frames keep coming
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_armed   = 1'b1;
      push_frame(FILL_RANDOM, 1'b0);
      push_frame(FILL_RANDOM, 1'b0);
      random_traffic(30);
      wait_all_done();

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("testbench: %0d bytes in, %0d frames passed (%0d data beats)",
               accepted_count, frames_passed, data_beats);
      $display("testbench: %0d bad length and %0d bad crc reports, %0d cycles",
               bad_len_seen, bad_crc_seen, cycle_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

FILE: framed_byte_receiver_crc16.f
rtl/fdm_pkg.sv
rtl/fdm_front.sv
rtl/fdm_queue.sv
rtl/fdm_back.sv
rtl/framed_byte_receiver_crc16.sv
dv/testbench.sv
